[hw/rtl/rpiv_pkg.sv]
// Shared types and widths for the inverse-pose view matrix pipeline.
package rpiv_pkg;

    localparam int QW    = 16;
    localparam int PW    = 32;
    localparam int PRODW = 32;
    localparam int NMW   = 34;
    localparam int PHW   = 50;
    localparam int PLW   = 51;
    localparam int SHW   = 46;
    localparam int SLW   = 53;
    localparam int ROTW  = 16;
    localparam int TRW   = 32;
    localparam int IN_W  = 4 * QW + 3 * PW;
    localparam int OUT_W = 9 * ROTW + 3 * TRW;

    typedef struct packed {
        logic signed [PW-1:0] pos_z;
        logic signed [PW-1:0] pos_y;
        logic signed [PW-1:0] pos_x;
        logic signed [QW-1:0] quat_w;
        logic signed [QW-1:0] quat_z;
        logic signed [QW-1:0] quat_y;
        logic signed [QW-1:0] quat_x;
    } pose_t;

    typedef struct packed {
        logic signed [TRW-1:0]  trans_z;
        logic signed [TRW-1:0]  trans_y;
        logic signed [TRW-1:0]  trans_x;
        logic signed [ROTW-1:0] rot_22;
        logic signed [ROTW-1:0] rot_21;
        logic signed [ROTW-1:0] rot_20;
        logic signed [ROTW-1:0] rot_12;
        logic signed [ROTW-1:0] rot_11;
        logic signed [ROTW-1:0] rot_10;
        logic signed [ROTW-1:0] rot_02;
        logic signed [ROTW-1:0] rot_01;
        logic signed [ROTW-1:0] rot_00;
    } view_t;

    typedef struct packed {
        logic signed [PRODW-1:0] xx;
        logic signed [PRODW-1:0] yy;
        logic signed [PRODW-1:0] zz;
        logic signed [PRODW-1:0] ww;
        logic signed [PRODW-1:0] xy;
        logic signed [PRODW-1:0] xz;
        logic signed [PRODW-1:0] yz;
        logic signed [PRODW-1:0] wx;
        logic signed [PRODW-1:0] wy;
        logic signed [PRODW-1:0] wz;
        logic [2:0][PW-1:0]      pos;
    } prod_t;

    typedef struct packed {
        logic [2:0][2:0][NMW-1:0] nm;
        logic [2:0][NMW-1:0]      diag;
        logic [2:0][PW-1:0]       pos;
    } mat_t;

    typedef struct packed {
        logic [2:0][SHW-1:0]      sh;
        logic [2:0][SLW-1:0]      sl;
        logic [2:0][2:0][NMW-1:0] rot;
    } xsum_t;

endpackage

[hw/rtl/rpiv_quat_prod.sv]
// Stage 1: pairwise quaternion component products.
module rpiv_quat_prod (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  rpiv_pkg::pose_t    in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rpiv_pkg::prod_t    out_data
);

    function automatic logic signed [rpiv_pkg::PRODW-1:0] mul(
        input logic signed [rpiv_pkg::QW-1:0] a,
        input logic signed [rpiv_pkg::QW-1:0] b
    );
        mul = a * b;
    endfunction

    logic            valid_reg;
    rpiv_pkg::prod_t data_reg;
    rpiv_pkg::prod_t data_next;

    always_comb begin
        data_next.xx  = mul(in_data.quat_x, in_data.quat_x);
        data_next.yy  = mul(in_data.quat_y, in_data.quat_y);
        data_next.zz  = mul(in_data.quat_z, in_data.quat_z);
        data_next.ww  = mul(in_data.quat_w, in_data.quat_w);
        data_next.xy  = mul(in_data.quat_x, in_data.quat_y);
        data_next.xz  = mul(in_data.quat_x, in_data.quat_z);
        data_next.yz  = mul(in_data.quat_y, in_data.quat_z);
        data_next.wx  = mul(in_data.quat_w, in_data.quat_x);
        data_next.wy  = mul(in_data.quat_w, in_data.quat_y);
        data_next.wz  = mul(in_data.quat_w, in_data.quat_z);
        data_next.pos = {in_data.pos_z, in_data.pos_y, in_data.pos_x};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

[hw/rtl/rpiv_rot_mat.sv]
// Stage 2: rotation matrix of the conjugate quaternion, homogeneous and unit forms.
module rpiv_rot_mat (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  rpiv_pkg::prod_t    in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rpiv_pkg::mat_t     out_data
);

    localparam logic signed [rpiv_pkg::NMW-1:0] ONE_Q28 = rpiv_pkg::NMW'(64'sd1 <<< 28);

    function automatic logic signed [rpiv_pkg::NMW-1:0] dbl_sum(
        input logic signed [rpiv_pkg::PRODW-1:0] a,
        input logic signed [rpiv_pkg::PRODW-1:0] b
    );
        logic signed [rpiv_pkg::NMW-1:0] s;
        s = rpiv_pkg::NMW'(a) + rpiv_pkg::NMW'(b);
        dbl_sum = s <<< 1;
    endfunction

    function automatic logic signed [rpiv_pkg::NMW-1:0] dbl_diff(
        input logic signed [rpiv_pkg::PRODW-1:0] a,
        input logic signed [rpiv_pkg::PRODW-1:0] b
    );
        logic signed [rpiv_pkg::NMW-1:0] s;
        s = rpiv_pkg::NMW'(a) - rpiv_pkg::NMW'(b);
        dbl_diff = s <<< 1;
    endfunction

    function automatic logic signed [rpiv_pkg::NMW-1:0] quad(
        input logic signed [rpiv_pkg::PRODW-1:0] a,
        input logic signed [rpiv_pkg::PRODW-1:0] b,
        input logic signed [rpiv_pkg::PRODW-1:0] c,
        input logic signed [rpiv_pkg::PRODW-1:0] d
    );
        quad = rpiv_pkg::NMW'(a) + rpiv_pkg::NMW'(b) - rpiv_pkg::NMW'(c)
             - rpiv_pkg::NMW'(d);
    endfunction

    logic           valid_reg;
    rpiv_pkg::mat_t data_reg;
    rpiv_pkg::mat_t data_next;

    always_comb begin
        data_next.nm[0][0] = quad(in_data.ww, in_data.xx, in_data.yy, in_data.zz);
        data_next.nm[0][1] = dbl_sum(in_data.xy, in_data.wz);
        data_next.nm[0][2] = dbl_diff(in_data.xz, in_data.wy);
        data_next.nm[1][0] = dbl_diff(in_data.xy, in_data.wz);
        data_next.nm[1][1] = quad(in_data.ww, in_data.yy, in_data.xx, in_data.zz);
        data_next.nm[1][2] = dbl_sum(in_data.yz, in_data.wx);
        data_next.nm[2][0] = dbl_sum(in_data.xz, in_data.wy);
        data_next.nm[2][1] = dbl_diff(in_data.yz, in_data.wx);
        data_next.nm[2][2] = quad(in_data.ww, in_data.zz, in_data.xx, in_data.yy);
        data_next.diag[0]  = ONE_Q28 - dbl_sum(in_data.yy, in_data.zz);
        data_next.diag[1]  = ONE_Q28 - dbl_sum(in_data.xx, in_data.zz);
        data_next.diag[2]  = ONE_Q28 - dbl_sum(in_data.xx, in_data.yy);
        data_next.pos      = in_data.pos;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

[hw/rtl/rpiv_xlate.sv]
// Stages 3 and 4: translation partial products, then row sums with clamp.
module rpiv_xlate (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  rpiv_pkg::mat_t     in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rpiv_pkg::xsum_t    out_data
);

    localparam int SUMHW = rpiv_pkg::PHW + 2;
    localparam logic signed [SUMHW-1:0] SH_LIMIT = SUMHW'(64'sd1 <<< 44);

    function automatic logic signed [rpiv_pkg::PHW-1:0] mul_h(
        input logic signed [rpiv_pkg::NMW-1:0] a,
        input logic signed [rpiv_pkg::QW-1:0]  b
    );
        mul_h = a * b;
    endfunction

    function automatic logic signed [rpiv_pkg::PLW-1:0] mul_l(
        input logic signed [rpiv_pkg::NMW-1:0] a,
        input logic signed [rpiv_pkg::QW:0]    b
    );
        mul_l = a * b;
    endfunction

    function automatic logic signed [SUMHW-1:0] sum_h(
        input logic signed [rpiv_pkg::PHW-1:0] a,
        input logic signed [rpiv_pkg::PHW-1:0] b,
        input logic signed [rpiv_pkg::PHW-1:0] c
    );
        sum_h = SUMHW'(a) + SUMHW'(b) + SUMHW'(c);
    endfunction

    function automatic logic signed [rpiv_pkg::SLW-1:0] sum_l(
        input logic signed [rpiv_pkg::PLW-1:0] a,
        input logic signed [rpiv_pkg::PLW-1:0] b,
        input logic signed [rpiv_pkg::PLW-1:0] c
    );
        sum_l = rpiv_pkg::SLW'(a) + rpiv_pkg::SLW'(b) + rpiv_pkg::SLW'(c);
    endfunction

    typedef struct packed {
        logic [2:0][2:0][rpiv_pkg::PHW-1:0] ph;
        logic [2:0][2:0][rpiv_pkg::PLW-1:0] pl;
        logic [2:0][2:0][rpiv_pkg::NMW-1:0] rot;
    } xmul_t;

    logic            mul_valid_reg;
    xmul_t           mul_reg;
    xmul_t           mul_next;
    logic            mul_ready;
    logic            sum_valid_reg;
    rpiv_pkg::xsum_t sum_reg;
    rpiv_pkg::xsum_t sum_next;
    logic signed [SUMHW-1:0] sh_raw;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                mul_next.ph[r][c] = mul_h(in_data.nm[r][c],
                                          in_data.pos[c][rpiv_pkg::PW-1:rpiv_pkg::QW]);
                mul_next.pl[r][c] = mul_l(in_data.nm[r][c],
                                          {1'b0, in_data.pos[c][rpiv_pkg::QW-1:0]});
                mul_next.rot[r][c] = (r == c) ? in_data.diag[r] : in_data.nm[r][c];
            end
        end
    end

    always_comb begin
        sh_raw = '0;
        for (int r = 0; r < 3; r++) begin
            sh_raw = sum_h(mul_reg.ph[r][0], mul_reg.ph[r][1], mul_reg.ph[r][2]);
            if (sh_raw > SH_LIMIT) begin
                sh_raw = SH_LIMIT;
            end else if (sh_raw < -SH_LIMIT) begin
                sh_raw = -SH_LIMIT;
            end
            sum_next.sh[r] = sh_raw[rpiv_pkg::SHW-1:0];
            sum_next.sl[r] = sum_l(mul_reg.pl[r][0], mul_reg.pl[r][1], mul_reg.pl[r][2]);
        end
        sum_next.rot = mul_reg.rot;
    end

    assign mul_ready = !sum_valid_reg || out_ready;
    assign in_ready  = !mul_valid_reg || mul_ready;
    assign out_valid = sum_valid_reg;
    assign out_data  = sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                mul_valid_reg <= in_valid;
            end
            if (mul_ready) begin
                sum_valid_reg <= mul_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            mul_reg <= mul_next;
        end
        if (mul_ready && mul_valid_reg) begin
            sum_reg <= sum_next;
        end
    end

endmodule

[hw/rtl/rpiv_out_fmt.sv]
// Stage 5: rounding, negation of the translation and saturation into the output register.
module rpiv_out_fmt (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  rpiv_pkg::xsum_t    in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rpiv_pkg::view_t    out_data
);

    localparam int RSUMW = rpiv_pkg::NMW + 1;
    localparam int RQW   = RSUMW - 14;
    localparam int TSUMW = 64;
    localparam int TQW   = TSUMW - 28;

    function automatic logic signed [rpiv_pkg::ROTW-1:0] fmt_rot(
        input logic signed [rpiv_pkg::NMW-1:0] v
    );
        logic signed [RSUMW-1:0] s;
        logic signed [RQW-1:0]   q;
        s = RSUMW'(v) + RSUMW'(64'sd1 <<< 13);
        q = RQW'(s >>> 14);
        if (q > RQW'(16'sh7FFF)) begin
            fmt_rot = 16'sh7FFF;
        end else if (q < -RQW'(17'sh08000)) begin
            fmt_rot = -16'sh8000;
        end else begin
            fmt_rot = q[rpiv_pkg::ROTW-1:0];
        end
    endfunction

    function automatic logic signed [rpiv_pkg::TRW-1:0] fmt_trans(
        input logic signed [rpiv_pkg::SHW-1:0] sh,
        input logic signed [rpiv_pkg::SLW-1:0] sl
    );
        logic signed [TSUMW-1:0] t;
        logic signed [TQW-1:0]   q;
        t = (TSUMW'(sh) <<< 16) + TSUMW'(sl);
        t = -t + TSUMW'(64'sd1 <<< 27);
        q = TQW'(t >>> 28);
        if (q > TQW'(32'sh7FFFFFFF)) begin
            fmt_trans = 32'sh7FFFFFFF;
        end else if (q < -TQW'(33'sh080000000)) begin
            fmt_trans = -32'sh80000000;
        end else begin
            fmt_trans = q[rpiv_pkg::TRW-1:0];
        end
    endfunction

    logic            valid_reg;
    rpiv_pkg::view_t data_reg;
    rpiv_pkg::view_t data_next;

    always_comb begin
        data_next.rot_00  = fmt_rot(in_data.rot[0][0]);
        data_next.rot_01  = fmt_rot(in_data.rot[0][1]);
        data_next.rot_02  = fmt_rot(in_data.rot[0][2]);
        data_next.rot_10  = fmt_rot(in_data.rot[1][0]);
        data_next.rot_11  = fmt_rot(in_data.rot[1][1]);
        data_next.rot_12  = fmt_rot(in_data.rot[1][2]);
        data_next.rot_20  = fmt_rot(in_data.rot[2][0]);
        data_next.rot_21  = fmt_rot(in_data.rot[2][1]);
        data_next.rot_22  = fmt_rot(in_data.rot[2][2]);
        data_next.trans_x = fmt_trans(in_data.sh[0], in_data.sl[0]);
        data_next.trans_y = fmt_trans(in_data.sh[1], in_data.sl[1]);
        data_next.trans_z = fmt_trans(in_data.sh[2], in_data.sl[2]);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

[hw/rtl/rigid_pose_inverse_to_view_matrix_core.sv]
// Top level: inverse rigid pose to view matrix, five-stage pipeline.
//
//  channel   direction  payload
//  s_        in         quaternion (Q2.14) and position (Q16.16)
//  m_        out        3x3 rotation (Q2.14) and translation (Q16.16)
//
// One transaction per cycle while m_tready does not stall the output.
// Stages: products, matrix, translation multiplies, row sums, round/saturate.
// Each stage holds a valid bit; a stage loads when empty or when its successor moves.
// Reset clears the valid bits only. Backpressure fills bubbles before stalling input.
module rigid_pose_inverse_to_view_matrix_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // quat_x, quat_y, quat_z, quat_w, pos_x, pos_y, pos_z
    input  logic [rpiv_pkg::IN_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // rot_00..rot_22 row-major, trans_x, trans_y, trans_z
    output logic [rpiv_pkg::OUT_W-1:0]  m_tdata
);

    rpiv_pkg::pose_t pose;
    rpiv_pkg::prod_t prod;
    rpiv_pkg::mat_t  mat;
    rpiv_pkg::xsum_t xsum;
    rpiv_pkg::view_t view;
    logic            prod_valid;
    logic            prod_ready;
    logic            mat_valid;
    logic            mat_ready;
    logic            xsum_valid;
    logic            xsum_ready;

    assign pose    = rpiv_pkg::pose_t'(s_tdata);
    assign m_tdata = view;

    rpiv_quat_prod u_quat_prod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (pose),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod)
    );

    rpiv_rot_mat u_rot_mat (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod),
        .out_valid (mat_valid),
        .out_ready (mat_ready),
        .out_data  (mat)
    );

    rpiv_xlate u_xlate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mat_valid),
        .in_ready  (mat_ready),
        .in_data   (mat),
        .out_valid (xsum_valid),
        .out_ready (xsum_ready),
        .out_data  (xsum)
    );

    rpiv_out_fmt u_out_fmt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (xsum_valid),
        .in_ready  (xsum_ready),
        .in_data   (xsum),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (view)
    );

endmodule

[hw/rtl/rpiv_checker.sv]
// Port-level checker for the inverse-pose view matrix core, with its bind.
module rpiv_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [rpiv_pkg::OUT_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed while stalled");

    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input stalled with output free");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready
        |=> m_tvalid)
        else $error("transaction missing at output after pipeline latency");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

endmodule

bind rigid_pose_inverse_to_view_matrix_core rpiv_checker u_rpiv_checker (.*);
